[rtl/ggx_microfacet_pdf_macros.svh]
// assertion macros shared by the ggx pdf checker
`ifndef GGX_MICROFACET_PDF_MACROS_SVH
`define GGX_MICROFACET_PDF_MACROS_SVH

// same-cycle implication, disabled in reset
`define GGXPDF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ggx_microfacet_pdf: check failed");

// next-cycle implication, disabled in reset
`define GGXPDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ggx_microfacet_pdf: check failed");

`endif

[rtl/ggxpdf_pkg.sv]
// shared types, constants and fixed-point helpers for the ggx pdf block
package ggxpdf_pkg;

   localparam int IN_FRAC_BITS  = 14;
   localparam int OUT_FRAC_BITS = 16;

   localparam int COS_W   = 16;
   localparam int ROUGH_W = 15;
   localparam int VALUE_W = 32;

   // internal magnitudes: Q.30 with room for 1.0
   localparam int QF = 30;
   localparam int QW = QF + 1;

   localparam logic [QW-1:0]   ONE_Q    = {1'b1, {QF{1'b0}}};
   localparam logic [QW-1:0]   INV_PI_Q = 31'd341782638;
   localparam logic [2*QW-1:0] HALF_P   = {{(2*QW-QF){1'b0}}, 1'b1, {(QF-1){1'b0}}};

   localparam int XW      = 2 * QW;                 // numerator a2/pi
   localparam int RAD_X_W = 2 * QF + 1;             // radicand shifted up by QF
   localparam int SQ_RW   = RAD_X_W + 1;            // root remainder
   localparam int ROOT_W  = QW;                     // root bits, one stage each
   localparam int DEN_W   = QW + 1;
   localparam int DW      = DEN_W + QW;             // divisor
   localparam int RMW     = DW + 1;                 // divider remainder
   localparam int NW      = XW + OUT_FRAC_BITS + 2; // dividend
   localparam int QUO_W   = VALUE_W + 1;            // quotient bits, one stage each
   localparam int NHI_W   = NW - QUO_W;
   localparam int CMP_W   = (RMW > NHI_W) ? RMW : NHI_W;

   localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

   localparam logic FUNC_PDF  = 1'b0;
   localparam logic FUNC_VNDF = 1'b1;

   typedef struct packed {
      logic                    func;
      logic signed [COS_W-1:0] cos_normal_half;
      logic signed [COS_W-1:0] cos_normal_out;
      logic signed [COS_W-1:0] cos_half_out;
      logic [ROUGH_W-1:0]      roughness;
   } ggxpdf_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      saturated;
      logic                      zero_cosine;
   } ggxpdf_rsp_type;

   // carried alongside the root pipeline
   typedef struct packed {
      logic          func;
      logic          kill;
      logic          zc;
      logic [QW-1:0] o;
      logic [QW-1:0] e2;
      logic [XW-1:0] x;
   } ggxpdf_sq_side_type;

   // carried alongside the divider pipeline
   typedef struct packed {
      logic kill;
      logic zc;
      logic dzero;
      logic xnz;
   } ggxpdf_div_side_type;

   // q.30 product, rounded half up
   function automatic logic [QW-1:0] mul_q(input logic [QW-1:0] x, input logic [QW-1:0] y);
      logic [2*QW-1:0] p;
      p = (2*QW)'(x) * (2*QW)'(y) + HALF_P;
      return QW'(p >> QF);
   endfunction

   // signed cosine to clipped q.30 magnitude
   function automatic logic [QW-1:0] cos_mag(input logic [COS_W-1:0] raw);
      logic [COS_W:0]    m;
      logic [COS_W+QF:0] w;
      m = raw[COS_W-1] ? (({1'b1, {COS_W{1'b0}}}) - {1'b0, raw}) : {1'b0, raw};
      w = (COS_W+QF+1)'(m) << (QF - IN_FRAC_BITS);
      if (w > (COS_W+QF+1)'(ONE_Q)) begin
         w = (COS_W+QF+1)'(ONE_Q);
      end
      return QW'(w);
   endfunction

   // unsigned roughness to clipped q.30
   function automatic logic [QW-1:0] rough_mag(input logic [ROUGH_W-1:0] raw);
      logic [ROUGH_W+QF-1:0] w;
      w = (ROUGH_W+QF)'(raw) << (QF - IN_FRAC_BITS);
      if (w > (ROUGH_W+QF)'(ONE_Q)) begin
         w = (ROUGH_W+QF)'(ONE_Q);
      end
      return QW'(w);
   endfunction

endpackage

[rtl/ggxpdf_isqrt.sv]
// pipelined integer square root, one root bit per stage
module ggxpdf_isqrt import ggxpdf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  ggxpdf_sq_side_type   in_side,
   input  logic [RAD_X_W-1:0]   in_rad,
   output logic                 out_valid,
   output ggxpdf_sq_side_type   out_side,
   output logic [ROOT_W-1:0]    out_root
);

   logic               vld_ff  [ROOT_W];
   ggxpdf_sq_side_type side_ff [ROOT_W];
   logic [ROOT_W-1:0]  root_ff [ROOT_W];
   logic [SQ_RW-1:0]   rem_ff  [ROOT_W-1];

   for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
      localparam int BIT = ROOT_W - 1 - j;
      logic               v_prev;
      ggxpdf_sq_side_type side_prev;
      logic [SQ_RW-1:0]   rem_prev;
      logic [ROOT_W-1:0]  root_prev;
      logic [SQ_RW-1:0]   trial;
      logic               fits;
      logic [SQ_RW-1:0]   rem_in;
      logic [ROOT_W-1:0]  root_in;

      if (j == 0) begin : g_first
         assign v_prev    = in_valid;
         assign side_prev = in_side;
         assign rem_prev  = SQ_RW'(in_rad);
         assign root_prev = '0;
      end else begin : g_next
         assign v_prev    = vld_ff[j-1];
         assign side_prev = side_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
      end

      // (r + 2^b)^2 - r^2
      assign trial   = (SQ_RW'(root_prev) << (BIT + 1)) + (SQ_RW'(1) << (2 * BIT));
      assign fits    = rem_prev >= trial;
      assign rem_in  = fits ? (rem_prev - trial) : rem_prev;
      assign root_in = fits ? (root_prev | (ROOT_W'(1) << BIT)) : root_prev;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[j] <= side_prev;
            root_ff[j] <= root_in;
         end
      end

      if (j < ROOT_W - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= rem_in;
            end
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];

endmodule

[rtl/ggxpdf_div.sv]
// pipelined restoring divider, overflow check then one quotient bit per stage
module ggxpdf_div import ggxpdf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  ggxpdf_div_side_type  in_side,
   input  logic [NW-1:0]        in_num,
   input  logic [DW-1:0]        in_den,
   output logic                 out_valid,
   output ggxpdf_div_side_type  out_side,
   output logic [QUO_W-1:0]     out_quo,
   output logic                 out_over
);

   logic                vld_ff  [QUO_W+1];
   ggxpdf_div_side_type side_ff [QUO_W+1];
   logic                over_ff [QUO_W+1];
   logic [QUO_W-1:0]    q_ff    [1:QUO_W];
   logic [RMW-1:0]      rem_ff  [QUO_W];
   logic [QUO_W-1:0]    nlo_ff  [QUO_W];
   logic [DW-1:0]       d_ff    [QUO_W];

   // stage 0: quotient would need more than QUO_W bits
   logic [NHI_W-1:0] nhi;
   logic             over_in;

   assign nhi     = in_num[NW-1:QUO_W];
   assign over_in = CMP_W'(nhi) >= CMP_W'(in_den);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         over_ff[0] <= over_in;
         rem_ff[0]  <= RMW'(nhi);
         nlo_ff[0]  <= in_num[QUO_W-1:0];
         d_ff[0]    <= in_den;
      end
   end

   for (genvar j = 1; j <= QUO_W; j++) begin : g_stage
      logic [QUO_W-1:0] q_prev;
      logic [RMW-1:0]   rem2;
      logic             fits;
      logic [RMW-1:0]   rem_in;
      logic [QUO_W-1:0] q_in;

      if (j == 1) begin : g_first
         assign q_prev = '0;
      end else begin : g_next
         assign q_prev = q_ff[j-1];
      end

      assign rem2   = {rem_ff[j-1][RMW-2:0], nlo_ff[j-1][QUO_W-1]};
      assign fits   = rem2 >= RMW'(d_ff[j-1]);
      assign rem_in = fits ? (rem2 - RMW'(d_ff[j-1])) : rem2;
      assign q_in   = {q_prev[QUO_W-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[j] <= side_ff[j-1];
            over_ff[j] <= over_ff[j-1];
            q_ff[j]    <= q_in;
         end
      end

      if (j < QUO_W) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= rem_in;
               nlo_ff[j] <= {nlo_ff[j-1][QUO_W-2:0], 1'b0};
               d_ff[j]   <= d_ff[j-1];
            end
         end
      end
   end

   assign out_valid = vld_ff[QUO_W];
   assign out_side  = side_ff[QUO_W];
   assign out_quo   = q_ff[QUO_W];
   assign out_over  = over_ff[QUO_W];

endmodule

[rtl/ggx_microfacet_pdf.sv]
// top level of the ggx microfacet pdf / visible normal density pipeline
//
// takes one shading sample per clock (three q1.14 cosines, roughness and a
// function select) and returns one q16.16 result per sample, in order. the
// work is fully pipelined: four arithmetic stages build a^2, the distribution
// denominator and the masking radicand, a 31-stage square root (one root bit
// per stage) finishes the smith term, one stage forms the divisor, and a
// 34-stage divider (overflow check plus one quotient bit per stage) gives the
// rounded, saturated quotient. sustained throughput is one item per cycle
// while results are taken. the output register is backed by a one-entry skid
// stage, so req_ready only falls once a result waits on the output and a
// second one sits in the skid stage; req_ready depends on registers alone.
// func 0 gives the sampling pdf g1 d / (4|n.o|), func 1 the visible normal
// value g1 d max(h.o,0) / |n.o|. a zero n.o gives 0 with zero_cosine set, a
// negative n.h gives 0, and a result beyond the output range is clipped to
// the largest value with saturated set.
module ggx_microfacet_pdf import ggxpdf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  ggxpdf_req_type req_data,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output ggxpdf_rsp_type rsp_data
);

   // pipeline advance: held only while the skid stage is occupied
   logic en;
   logic skid_v_ff;
   logic out_v_ff;
   logic take;

   assign en        = !skid_v_ff;
   assign req_ready = en;
   assign take      = out_v_ff && rsp_ready;

   // ---------------- stage 1: magnitudes and special cases ----------------
   logic          c_neg, o_neg, h_neg;
   logic [QW-1:0] cq, oq, hq, aq;
   logic          kill_in, zc_in;

   assign c_neg = req_data.cos_normal_half[COS_W-1];
   assign o_neg = req_data.cos_normal_out[COS_W-1];
   assign h_neg = req_data.cos_half_out[COS_W-1];
   assign cq    = cos_mag(req_data.cos_normal_half);
   assign oq    = cos_mag(req_data.cos_normal_out);
   assign hq    = cos_mag(req_data.cos_half_out);
   assign aq    = rough_mag(req_data.roughness);

   // negative n.h kills everything; zero n.o flags; then zero h.o, sign mismatches and, for vndf, negative h.o kill
   assign zc_in   = !c_neg && (oq == '0);
   assign kill_in = c_neg || ((oq != '0) && ((hq == '0) || (h_neg != o_neg) ||
                    ((req_data.func == FUNC_VNDF) && h_neg)));

   logic          s1_v_ff, s1_func_ff, s1_kill_ff, s1_zc_ff;
   logic [QW-1:0] s1_c_ff, s1_o_ff, s1_h_ff, s1_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_func_ff <= req_data.func;
         s1_kill_ff <= kill_in;
         s1_zc_ff   <= zc_in;
         s1_c_ff    <= cq;
         s1_o_ff    <= oq;
         s1_h_ff    <= hq;
         s1_a_ff    <= aq;
      end
   end

   // ---------------- stage 2: squares ----------------
   logic          s2_v_ff, s2_func_ff, s2_kill_ff, s2_zc_ff;
   logic [QW-1:0] s2_o_ff, s2_h_ff, s2_a2_ff, s2_c2_ff, s2_o2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_func_ff <= s1_func_ff;
         s2_kill_ff <= s1_kill_ff;
         s2_zc_ff   <= s1_zc_ff;
         s2_o_ff    <= s1_o_ff;
         s2_h_ff    <= s1_h_ff;
         s2_a2_ff   <= mul_q(s1_a_ff, s1_a_ff);
         s2_c2_ff   <= mul_q(s1_c_ff, s1_c_ff);
         s2_o2_ff   <= mul_q(s1_o_ff, s1_o_ff);
      end
   end

   // ---------------- stage 3: products with (1 - a^2), h a^2 ----------------
   logic [QW-1:0] om;
   assign om = ONE_Q - s2_a2_ff;

   logic          s3_v_ff, s3_func_ff, s3_kill_ff, s3_zc_ff;
   logic [QW-1:0] s3_o_ff, s3_a2_ff, s3_t1_ff, s3_t2_ff, s3_ha2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_func_ff <= s2_func_ff;
         s3_kill_ff <= s2_kill_ff;
         s3_zc_ff   <= s2_zc_ff;
         s3_o_ff    <= s2_o_ff;
         s3_a2_ff   <= s2_a2_ff;
         s3_t1_ff   <= mul_q(s2_c2_ff, om);
         s3_t2_ff   <= mul_q(om, s2_o2_ff);
         s3_ha2_ff  <= mul_q(s2_h_ff, s2_a2_ff);
      end
   end

   // ---------------- stage 4: e^2, radicand, numerator ----------------
   logic [QW-1:0] e_q, num_sel;
   assign e_q     = ONE_Q - s3_t1_ff;
   assign num_sel = (s3_func_ff == FUNC_VNDF) ? s3_ha2_ff : s3_a2_ff;

   logic               s4_v_ff;
   ggxpdf_sq_side_type s4_side_ff;
   logic [QW-1:0]      s4_rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (en) begin
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_side_ff.func <= s3_func_ff;
         s4_side_ff.kill <= s3_kill_ff;
         s4_side_ff.zc   <= s3_zc_ff;
         s4_side_ff.o    <= s3_o_ff;
         s4_side_ff.e2   <= mul_q(e_q, e_q);
         s4_side_ff.x    <= XW'(num_sel) * XW'(INV_PI_Q);
         s4_rad_ff       <= s3_a2_ff + s3_t2_ff;
      end
   end

   // ---------------- square root of the masking radicand ----------------
   logic               sq_v;
   ggxpdf_sq_side_type sq_side;
   logic [ROOT_W-1:0]  sq_root;

   ggxpdf_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_v_ff),
      .in_side   (s4_side_ff),
      .in_rad    ({s4_rad_ff, {QF{1'b0}}}),
      .out_valid (sq_v),
      .out_side  (sq_side),
      .out_root  (sq_root)
   );

   // ---------------- stage 5: divisor and dividend ----------------
   logic [DEN_W-1:0] den;
   assign den = DEN_W'(sq_side.o) + DEN_W'(sq_root);

   logic                s5_v_ff;
   ggxpdf_div_side_type s5_side_ff;
   logic [NW-1:0]       s5_num_ff;
   logic [DW-1:0]       s5_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else if (en) begin
         s5_v_ff <= sq_v;
      end
   end

   // pdf divides by 2 den e2 at one less shift, same as den e2 at this shift
   always_ff @(posedge clock) begin
      if (en) begin
         s5_side_ff.kill  <= sq_side.kill;
         s5_side_ff.zc    <= sq_side.zc;
         s5_side_ff.dzero <= (den == '0) || (sq_side.e2 == '0);
         s5_side_ff.xnz   <= sq_side.x != '0;
         s5_den_ff        <= DW'(den) * DW'(sq_side.e2);
         s5_num_ff        <= (sq_side.func == FUNC_VNDF) ?
                             (NW'(sq_side.x) << (OUT_FRAC_BITS + 2)) :
                             (NW'(sq_side.x) << OUT_FRAC_BITS);
      end
   end

   // ---------------- divider ----------------
   logic                dv_v;
   ggxpdf_div_side_type dv_side;
   logic [QUO_W-1:0]    dv_quo;
   logic                dv_over;

   ggxpdf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s5_v_ff),
      .in_side   (s5_side_ff),
      .in_num    (s5_num_ff),
      .in_den    (s5_den_ff),
      .out_valid (dv_v),
      .out_side  (dv_side),
      .out_quo   (dv_quo),
      .out_over  (dv_over)
   );

   // ---------------- rounding, saturation, special results ----------------
   logic             sat_q;
   logic [QUO_W:0]   q_round;
   ggxpdf_rsp_type   fin;

   assign sat_q   = dv_over || (dv_quo >= QUO_W'({VALUE_W{1'b1}}));
   assign q_round = (QUO_W+1)'(dv_quo) + (QUO_W+1)'(1);

   always_comb begin
      fin = '0;
      priority if (dv_side.kill) begin
         fin = '0;
      end else if (dv_side.zc) begin
         fin.zero_cosine = 1'b1;
      end else if (dv_side.dzero) begin
         if (dv_side.xnz) begin
            fin.value     = VALUE_MAX;
            fin.saturated = 1'b1;
         end
      end else if (sat_q) begin
         fin.value     = VALUE_MAX;
         fin.saturated = 1'b1;
      end else begin
         fin.value = VALUE_W'(q_round >> 1);
      end
   end

   // ---------------- output register and skid stage ----------------
   ggxpdf_rsp_type out_ff, out_in, skid_ff, skid_in;
   logic           out_v_in, skid_v_in;

   always_comb begin
      out_in    = out_ff;
      out_v_in  = out_v_ff;
      skid_in   = skid_ff;
      skid_v_in = skid_v_ff;
      if (skid_v_ff) begin
         if (take) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (en && dv_v) begin
         if (!out_v_ff || take) begin
            out_in   = fin;
            out_v_in = 1'b1;
         end else begin
            skid_in   = fin;
            skid_v_in = 1'b1;
         end
      end else if (take) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

endmodule

[rtl/ggxpdf_checker.sv]
// port-level checks for the ggx pdf block, bound to the top level
`include "ggx_microfacet_pdf_macros.svh"

module ggxpdf_checker import ggxpdf_pkg::*; (
   input logic           clock,
   input logic           reset,
   input logic           req_valid,
   input logic           req_ready,
   input ggxpdf_req_type req_data,
   input logic           rsp_valid,
   input logic           rsp_ready,
   input ggxpdf_rsp_type rsp_data
);

   // a stalled result holds until its transfer
   `GGXPDF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // zero cosine always forces a clean zero
   `GGXPDF_ASSERT_NOW(a_zc_zero, clock, reset, rsp_valid && rsp_data.zero_cosine, (rsp_data.value == '0) && !rsp_data.saturated)

   // saturation only ever clips to the top of the range
   `GGXPDF_ASSERT_NOW(a_sat_max, clock, reset, rsp_valid && rsp_data.saturated, rsp_data.value == VALUE_MAX)

   // a density is never negative
   `GGXPDF_ASSERT_NOW(a_nonneg, clock, reset, rsp_valid, !rsp_data.value[VALUE_W-1])

endmodule

bind ggx_microfacet_pdf ggxpdf_checker u_checker (.*);
